/* hdl/rlptfe_pkg.sv */
// Shared types and constants for the RLP transaction field extractor.
// Used by the top level, its checker and the testbench; no other dependencies.
package rlptfe_pkg;

  // Default depth of the header gather buffer
  localparam int HEADER_BYTES_DEF = 5;
  // Length bounds for integer fields and for the recipient address
  localparam logic [31:0] INT_MAX_BYTES  = 32'd32;
  localparam logic [31:0] ADDR_MAX_BYTES = 32'd20;

  // Field order of a signed transaction
  localparam logic [3:0] FLD_ENVELOPE  = 4'd0;
  localparam logic [3:0] FLD_TYPE      = 4'd1;
  localparam logic [3:0] FLD_NONCE     = 4'd2;
  localparam logic [3:0] FLD_GAS_PRICE = 4'd3;
  localparam logic [3:0] FLD_START_GAS = 4'd4;
  localparam logic [3:0] FLD_VALUE     = 4'd5;
  localparam logic [3:0] FLD_RECIPIENT = 4'd6;
  localparam logic [3:0] FLD_DATA      = 4'd7;
  localparam logic [3:0] FLD_V         = 4'd8;
  localparam logic [3:0] FLD_R         = 4'd9;
  localparam logic [3:0] FLD_S         = 4'd10;
  localparam logic [3:0] FLD_DONE      = 4'd11;

  // RLP header prefix boundaries
  localparam logic [7:0] RLP_STR_SHORT  = 8'h80;
  localparam logic [7:0] RLP_STR_LONG   = 8'hb8;
  localparam logic [7:0] RLP_LIST_SHORT = 8'hc0;
  localparam logic [7:0] RLP_LIST_LONG  = 8'hf8;

  // Input op codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [1:0] {
    STATUS_PROCESSING = 2'd0,
    STATUS_FINISHED   = 2'd1,
    STATUS_FAULT      = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        hash_valid;
    logic [7:0]  hash_byte;
    logic [3:0]  field_id;
    logic        capture_valid;
    logic [4:0]  capture_pos;
    logic [7:0]  capture_byte;
    logic        field_done;
    logic [31:0] field_length;
    logic        contract_call_valid;
    logic        contract_call;
  } result_t;

  // Fields whose value bytes are forwarded for capture
  function automatic logic field_kept(input logic [3:0] fid);
    return (fid == FLD_GAS_PRICE) || (fid == FLD_START_GAS) || (fid == FLD_VALUE) ||
           (fid == FLD_RECIPIENT) || (fid == FLD_V);
  endfunction

endpackage

/* hdl/rlp_tx_field_extractor.sv */
// Top level of the RLP transaction field extractor: header decode, field walk,
// result register. Depends on rlptfe_pkg.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+------------------------------------
//   in       | in_valid / in_ready            | op, data_byte
//   out      | out_valid / out_ready          | status, hash_*, field_id, capture_*,
//            |                                | field_done, field_length, contract_*
//   cfg      | cfg_wr_en (no wait)            | cfg_wr_data -> has_type_field
//
// One transfer in yields one transfer out, presented in the cycle after it. A new
// byte is taken every cycle while the result register is empty or being drained;
// the rate is set by the single result register in front of the output.
// rst (synchronous) clears the parser and has_type_field. A stall on out holds the
// result and backs up the input through in_ready; nothing is dropped.
module rlp_tx_field_extractor
  import rlptfe_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  data_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        hash_valid,
  output logic [7:0]  hash_byte,
  output logic [3:0]  field_id,
  output logic        capture_valid,
  output logic [4:0]  capture_pos,
  output logic [7:0]  capture_byte,
  output logic        field_done,
  output logic [31:0] field_length,
  output logic        contract_call_valid,
  output logic        contract_call
);

  localparam int HCW  = $clog2(HEADER_BYTES + 1);
  localparam int CMPW = (HCW > 4) ? HCW : 4;

  // configuration register
  logic has_type_field;

  // parser state
  logic [3:0]     field_index, field_index_next;
  logic           in_field, in_field_next;
  logic [31:0]    field_pos, field_pos_next;
  logic [31:0]    field_len, field_len_next;
  logic [HCW-1:0] header_count, header_count_next;
  logic [7:0]     hdr_first, hdr_first_next;   // first header byte (prefix)
  logic [31:0]    len_acc, len_acc_next;       // long-form length bytes, MSB first
  logic           finished_flag, finished_flag_next;
  logic           fault_flag, fault_flag_next;

  // result register
  logic    res_valid;
  result_t res, res_next;

  logic accept;

  // header decode
  logic [HCW-1:0]  hc_inc;
  logic [7:0]      h0;
  logic [3:0]      hdr_n;
  logic [CMPW-1:0] hc_cmp, need_cmp;
  logic            long_form, hdr_list, hdr_single;
  logic [31:0]     hdr_len;
  // value-byte walk
  logic            proceed, data_now;
  logic [31:0]     pos_cur, len_cur, pos_new;
  logic [3:0]      fid_inc;
  logic            fault_set;
  logic            over_bound;

  assign in_ready = !res_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    field_index_next   = field_index;
    in_field_next      = in_field;
    field_pos_next     = field_pos;
    field_len_next     = field_len;
    header_count_next  = header_count;
    hdr_first_next     = hdr_first;
    len_acc_next       = len_acc;
    finished_flag_next = finished_flag;
    fault_flag_next    = fault_flag;

    res_next          = '0;
    res_next.field_id = field_index;

    hc_inc     = header_count + 1'b1;
    h0         = (header_count == '0) ? data_byte : hdr_first;
    long_form  = (h0 >= RLP_STR_LONG && h0 < RLP_LIST_SHORT) || (h0 >= RLP_LIST_LONG);
    hdr_n      = long_form ? ({1'b0, h0[2:0]} + 4'd1) : 4'd0;
    hc_cmp     = CMPW'(hc_inc);
    need_cmp   = CMPW'(hdr_n) + CMPW'(1);
    hdr_list   = (h0 >= RLP_LIST_SHORT);
    hdr_single = (h0 < RLP_STR_SHORT);
    len_acc_next = (header_count == '0) ? 32'd0 : {len_acc[23:0], data_byte};
    hdr_len    = 32'd1;
    if (hdr_single) begin
      hdr_len = 32'd1;
    end else if (long_form) begin
      hdr_len = len_acc_next;
    end else if (h0 < RLP_STR_LONG) begin
      hdr_len = {25'd0, h0[6:0]};
    end else begin
      hdr_len = {26'd0, h0[5:0]};
    end

    over_bound = ((field_index == FLD_RECIPIENT) && (hdr_len > ADDR_MAX_BYTES)) ||
                 (((field_index >= FLD_TYPE && field_index <= FLD_VALUE) ||
                   (field_index == FLD_V)) && (hdr_len > INT_MAX_BYTES));

    proceed   = 1'b0;
    data_now  = 1'b0;
    fault_set = 1'b0;
    pos_cur   = field_pos;
    len_cur   = field_len;
    pos_new   = field_pos;
    fid_inc   = field_index + 4'd1;

    if (op == OP_RESTART) begin
      // restart: drop everything but the configuration register
      field_index_next   = FLD_ENVELOPE;
      in_field_next      = 1'b0;
      field_pos_next     = '0;
      field_len_next     = '0;
      header_count_next  = '0;
      finished_flag_next = 1'b0;
      fault_flag_next    = 1'b0;
      res_next.field_id  = FLD_ENVELOPE;
    end else if (fault_flag || finished_flag || field_index > FLD_S) begin
      fault_set = 1'b1;
    end else if (!in_field) begin
      if (header_count >= HCW'(HEADER_BYTES)) begin
        fault_set = 1'b1;
      end else begin
        header_count_next   = hc_inc;
        hdr_first_next      = h0;
        res_next.hash_valid = 1'b1;
        res_next.hash_byte  = data_byte;
        if (hc_cmp < need_cmp) begin
          // header still incomplete: gather next byte
        end else if (hdr_n > 4'd4) begin
          fault_set = 1'b1;
        end else begin
          header_count_next = '0;
          field_pos_next    = '0;
          field_len_next    = hdr_len;
          in_field_next     = 1'b1;
          if (field_index == FLD_ENVELOPE) begin
            if (!hdr_list) begin
              fault_set = 1'b1;
            end else begin
              field_index_next      = has_type_field ? FLD_TYPE : FLD_NONCE;
              in_field_next         = 1'b0;
              res_next.field_done   = 1'b1;
              res_next.field_length = hdr_len;
            end
          end else if (hdr_list || over_bound) begin
            fault_set = 1'b1;
          end else begin
            if (field_index == FLD_DATA) begin
              // contract call: length is 4 plus a multiple of 32
              res_next.contract_call_valid = 1'b1;
              res_next.contract_call = (hdr_len >= 32'd4) && (hdr_len[4:0] == 5'd4);
            end
            proceed  = 1'b1;
            data_now = hdr_single;
            pos_cur  = '0;
            len_cur  = hdr_len;
          end
        end
      end
    end else begin
      res_next.hash_valid = 1'b1;
      res_next.hash_byte  = data_byte;
      proceed  = 1'b1;
      data_now = 1'b1;
    end

    if (proceed) begin
      pos_new = pos_cur;
      if (data_now && pos_cur < len_cur) begin
        if (field_kept(field_index)) begin
          res_next.capture_valid = 1'b1;
          res_next.capture_pos   = pos_cur[4:0];
          res_next.capture_byte  = data_byte;
        end
        pos_new = pos_cur + 32'd1;
      end
      field_pos_next = pos_new;
      if (pos_new == len_cur) begin
        // field complete: advance to the next one
        res_next.field_done   = 1'b1;
        res_next.field_length = len_cur;
        field_index_next      = fid_inc;
        in_field_next         = 1'b0;
        if (fid_inc == FLD_DONE) begin
          finished_flag_next = 1'b1;
        end
      end
    end

    if (op == OP_RESTART) begin
      res_next.status = STATUS_PROCESSING;
    end else if (fault_set) begin
      // sticky fault: hold field_id, clear everything else
      fault_flag_next   = 1'b1;
      res_next          = '0;
      res_next.status   = STATUS_FAULT;
      res_next.field_id = field_index;
    end else begin
      res_next.status = finished_flag_next ? STATUS_FINISHED : STATUS_PROCESSING;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      has_type_field <= 1'b0;
    end else if (cfg_wr_en) begin
      has_type_field <= cfg_wr_data;
    end
  end

  // parser state, updated once per input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      field_index   <= FLD_ENVELOPE;
      in_field      <= 1'b0;
      field_pos     <= '0;
      field_len     <= '0;
      header_count  <= '0;
      finished_flag <= 1'b0;
      fault_flag    <= 1'b0;
    end else if (accept) begin
      field_index   <= field_index_next;
      in_field      <= in_field_next;
      field_pos     <= field_pos_next;
      field_len     <= field_len_next;
      header_count  <= header_count_next;
      finished_flag <= finished_flag_next;
      fault_flag    <= fault_flag_next;
    end
  end

  // header scratch: only read after being written in the same header
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_first <= hdr_first_next;
      len_acc   <= len_acc_next;
    end
  end

  // result register: load on input transfer, drop on output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign out_valid           = res_valid;
  assign status              = res.status;
  assign hash_valid          = res.hash_valid;
  assign hash_byte           = res.hash_byte;
  assign field_id            = res.field_id;
  assign capture_valid       = res.capture_valid;
  assign capture_pos         = res.capture_pos;
  assign capture_byte        = res.capture_byte;
  assign field_done          = res.field_done;
  assign field_length        = res.field_length;
  assign contract_call_valid = res.contract_call_valid;
  assign contract_call       = res.contract_call;

endmodule

/* hdl/rlptfe_checker.sv */
// Port-level checker for rlp_tx_field_extractor, bound to the top level.
// Depends on rlptfe_pkg.
module rlptfe_checker
  import rlptfe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        hash_valid,
  input logic [7:0]  hash_byte,
  input logic        capture_valid,
  input logic [4:0]  capture_pos,
  input logic        field_done,
  input logic        contract_call_valid,
  input logic        contract_call
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_byte) && $stable(capture_pos))
    else $error("stalled result changed or dropped");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // a fault result carries nothing else
  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FAULT |->
      !hash_valid && !capture_valid && !field_done && !contract_call_valid)
    else $error("fault result carries payload");

  // a captured byte is always also a hashed byte
  a_capture_hashed: assert property (@(posedge clk) disable iff (rst)
    out_valid && capture_valid |-> hash_valid)
    else $error("captured byte not hashed");

  // contract flag only with its qualifier
  a_contract_qual: assert property (@(posedge clk) disable iff (rst)
    out_valid && contract_call |-> contract_call_valid)
    else $error("contract_call without contract_call_valid");

endmodule

bind rlp_tx_field_extractor rlptfe_checker u_rlptfe_checker (.*);

/* tb/sv/rlptfe_result_check.sv */
// Result checker for the RLP transaction field extractor: watches both channels and
// the config port, predicts each result and compares it on the output transfer.
// Depends on rlptfe_pkg.
`timescale 1ns / 100ps

module rlptfe_result_check
  import rlptfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        op,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic        hash_valid,
  input  logic [7:0]  hash_byte,
  input  logic [3:0]  field_id,
  input  logic        capture_valid,
  input  logic [4:0]  capture_pos,
  input  logic [7:0]  capture_byte,
  input  logic        field_done,
  input  logic [31:0] field_length,
  input  logic        contract_call_valid,
  input  logic        contract_call,
  output int          error_count,
  output int          backlog
);

  // Parser state, kept apart from the block
  logic        type_en;
  logic [3:0]  fld_idx;
  logic        in_fld;
  logic        single_fld;
  logic        fld_list;
  logic [31:0] fld_pos;
  logic [31:0] fld_len;
  logic [7:0]  hdr_buf [HEADER_BYTES_DEF];
  int          hdr_cnt;
  logic        tx_done;
  logic        tx_fault;

  result_t     parsed_q [$];

  task automatic reset_parser();
    fld_idx    = FLD_ENVELOPE;
    in_fld     = 1'b0;
    single_fld = 1'b0;
    fld_list   = 1'b0;
    fld_pos    = '0;
    fld_len    = '0;
    hdr_cnt    = 0;
    tx_done    = 1'b0;
    tx_fault   = 1'b0;
    foreach (hdr_buf[i]) hdr_buf[i] = '0;
  endtask

  // Advance the parser by one transfer and work out the result it must produce
  task automatic parse_tx_byte(input logic op_in, input logic [7:0] b, output result_t r);
    logic [3:0]  fid;
    logic        data_now;
    logic        stop;
    logic        list;
    logic [7:0]  h0;
    logic [31:0] len;
    int          n;
    r    = '0;
    fid  = fld_idx;
    stop = 1'b0;
    if (op_in == OP_RESTART) begin
      reset_parser();
      return;
    end
    if (tx_fault) begin
      stop = 1'b1;
    end else if (tx_done || fld_idx > FLD_S) begin
      tx_fault = 1'b1;
      stop     = 1'b1;
    end
    if (!stop) begin
      data_now = in_fld;
      if (!in_fld) begin
        if (hdr_cnt >= HEADER_BYTES_DEF) begin
          tx_fault = 1'b1;
          stop     = 1'b1;
        end else begin
          hdr_buf[hdr_cnt] = b;
          hdr_cnt++;
          h0 = hdr_buf[0];
          n  = 0;
          if (h0 >= RLP_STR_LONG && h0 < RLP_LIST_SHORT) n = int'(h0) - int'(RLP_STR_LONG) + 1;
          else if (h0 >= RLP_LIST_LONG) n = int'(h0) - int'(RLP_LIST_LONG) + 1;
          r.hash_valid = 1'b1;
          r.hash_byte  = b;
          if (hdr_cnt < n + 1) begin
            stop = 1'b1;
          end else if (n > 4) begin
            tx_fault = 1'b1;
            stop     = 1'b1;
          end else begin
            list = (h0 >= RLP_LIST_SHORT);
            if (h0 < RLP_STR_SHORT) begin
              len = 32'd1;
            end else if (h0 < RLP_STR_LONG) begin
              len = h0 - RLP_STR_SHORT;
            end else if (h0 < RLP_LIST_SHORT || h0 >= RLP_LIST_LONG) begin
              len = '0;
              for (int i = 1; i <= n; i++) len = {len[23:0], hdr_buf[i]};
            end else begin
              len = h0 - RLP_LIST_SHORT;
            end
            hdr_cnt  = 0;
            fld_pos  = '0;
            fld_len  = len;
            fld_list = list;
            in_fld   = 1'b1;
            if (h0 < RLP_STR_SHORT) begin
              single_fld = 1'b1;
              data_now   = 1'b1;
            end
            if (fld_idx == FLD_ENVELOPE) begin
              if (!list) begin
                tx_fault = 1'b1;
              end else begin
                fld_idx        = type_en ? FLD_TYPE : FLD_NONCE;
                in_fld         = 1'b0;
                r.field_done   = 1'b1;
                r.field_length = len;
              end
              stop = 1'b1;
            end else if (list ||
                         (fld_idx == FLD_RECIPIENT && len > ADDR_MAX_BYTES) ||
                         (((fld_idx >= FLD_TYPE && fld_idx <= FLD_VALUE) || fld_idx == FLD_V) &&
                          len > INT_MAX_BYTES)) begin
              tx_fault = 1'b1;
              stop     = 1'b1;
            end else if (fld_idx == FLD_DATA) begin
              r.contract_call_valid = 1'b1;
              r.contract_call       = (len >= 32'd4) && ((len - 32'd4) % 32'd32 == 0);
            end
          end
        end
      end else if (!single_fld) begin
        r.hash_valid = 1'b1;
        r.hash_byte  = b;
      end
      if (!stop) begin
        if (data_now && fld_pos < fld_len) begin
          if (fld_idx inside {FLD_GAS_PRICE, FLD_START_GAS, FLD_VALUE, FLD_RECIPIENT, FLD_V})
          begin
            r.capture_valid = 1'b1;
            r.capture_pos   = fld_pos[4:0];
            r.capture_byte  = b;
          end
          fld_pos++;
        end
        if (fld_pos == fld_len) begin
          r.field_done   = 1'b1;
          r.field_length = fld_len;
          fld_idx++;
          in_fld     = 1'b0;
          single_fld = 1'b0;
          if (fld_idx == FLD_DONE) tx_done = 1'b1;
        end
      end
    end
    if (tx_fault) begin
      r        = '0;
      r.status = STATUS_FAULT;
    end else begin
      r.status = tx_done ? STATUS_FINISHED : STATUS_PROCESSING;
    end
    r.field_id = fid;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      error_count++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      type_en     = 1'b0;
      error_count = 0;
      reset_parser();
      parsed_q.delete();
    end else begin
      if (cfg_wr_en) type_en = cfg_wr_data;
      // Drain first: a result never leaves in the cycle its byte arrives
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          error_count++;
          $error("result transfer with no prediction pending");
        end else begin
          want = parsed_q.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("hash_valid", 32'(want.hash_valid), 32'(hash_valid));
          check_field("hash_byte", 32'(want.hash_byte), 32'(hash_byte));
          check_field("field_id", 32'(want.field_id), 32'(field_id));
          check_field("capture_valid", 32'(want.capture_valid), 32'(capture_valid));
          check_field("capture_pos", 32'(want.capture_pos), 32'(capture_pos));
          check_field("capture_byte", 32'(want.capture_byte), 32'(capture_byte));
          check_field("field_done", 32'(want.field_done), 32'(field_done));
          check_field("field_length", want.field_length, field_length);
          check_field("contract_call_valid", 32'(want.contract_call_valid),
                      32'(contract_call_valid));
          check_field("contract_call", 32'(want.contract_call), 32'(contract_call));
        end
      end
      if (in_valid && in_ready) begin
        parse_tx_byte(op, data_byte, want);
        parsed_q.push_back(want);
      end
    end
    backlog <= parsed_q.size();
  end

endmodule

/* tb/sv/tb_rlp_tx_field_extractor.sv */
// Testbench top for the RLP transaction field extractor: clock, reset, byte stimulus
// and output back-pressure; checking is done by rlptfe_result_check.
// Depends on rlptfe_pkg, rlp_tx_field_extractor and rlptfe_result_check.
`timescale 1ns / 100ps

module tb_rlp_tx_field_extractor
  import rlptfe_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        hash_valid;
  logic [7:0]  hash_byte;
  logic [3:0]  field_id;
  logic        capture_valid;
  logic [4:0]  capture_pos;
  logic [7:0]  capture_byte;
  logic        field_done;
  logic [31:0] field_length;
  logic        contract_call_valid;
  logic        contract_call;
  int          error_count;
  int          backlog;

  // Idle rates in percent of cycles, per stimulus phase
  int          send_gap_pct [3] = '{22, 76, 0};
  int          recv_gap_pct [3] = '{76, 22, 0};
  int          send_idle_pct;
  int          recv_idle_pct;

  int          items_sent;
  logic        type_on;       // our copy of has_type_field, used to shape transactions
  logic [7:0]  frame_q [$];   // bytes of the next transaction, sent after a restart

  rlp_tx_field_extractor u_top (.*);
  rlptfe_result_check    u_check (.*);

  always #10 clk = ~clk;

  // Receiver: drop ready at random, at the rate of the current phase
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // Hard stop in case the handshake locks up
  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  // Offer one transfer, idling at random first; valid stays up after acceptance so
  // back-to-back items never lower and raise it in the same step.
  task automatic send_item(input logic op_v, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= op_v;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Restart the parser, then stream the prepared transaction bytes
  task automatic send_frame();
    send_item(OP_RESTART, 8'($urandom));
    foreach (frame_q[i]) send_item(OP_BYTE, frame_q[i]);
  endtask

  // Hold the sender until every predicted result has drained, then write the register
  task automatic settle_and_set_type(input logic v);
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    type_on      = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Append one RLP string of the given length; mix short, long and self-encoded forms.
  // Long forms use 1..4 length bytes, leading zeros included, so the header
  // buffer gets filled to the brim now and then.
  task automatic push_string(input int len);
    int nb;
    if (len == 1 && $urandom_range(0, 1)) begin
      frame_q.push_back(8'($urandom_range(0, 127)));
      return;
    end
    if (len <= 55 && $urandom_range(0, 3) != 0) begin
      frame_q.push_back(RLP_STR_SHORT + 8'(len));
    end else begin
      nb = (len > 255) ? $urandom_range(2, 4) : $urandom_range(1, 4);
      frame_q.push_back(RLP_STR_LONG + 8'(nb - 1));
      for (int i = nb - 1; i >= 0; i--) frame_q.push_back(8'(len >> (8 * i)));
    end
    repeat (len) frame_q.push_back(8'($urandom));
  endtask

  // Field lengths: mostly short, with the bounds and the contract-call sizes mixed in
  function automatic int pick_len(input int f);
    int r;
    r = $urandom_range(0, 39);
    if (f == FLD_RECIPIENT) return (r < 14) ? 20 : $urandom_range(0, 4);
    if (f == FLD_DATA) begin
      if (r < 8) return 4 + 32 * $urandom_range(0, 1);
      if (r == 8) return $urandom_range(56, 300);
      return $urandom_range(0, 12);
    end
    if (f == FLD_R || f == FLD_S) return (r < 4) ? 32 : $urandom_range(0, 4);
    if (f == FLD_V) return (r < 30) ? 1 : $urandom_range(0, 3);
    if (r < 2) return 32;
    if (r == 2) return 31;
    return $urandom_range(0, 4);
  endfunction

  // Build one transaction: mostly well formed, some truncated, some with a bad
  // field or trailing bytes after the finish, and some plain noise.
  task automatic build_tx();
    int mode;
    int bad_fld;
    int bad_kind;
    int n;
    frame_q.delete();
    mode     = $urandom_range(0, 99);
    bad_fld  = (mode >= 80 && mode < 90) ? $urandom_range(0, 10) : -1;
    bad_kind = $urandom_range(0, 2);
    if (mode >= 90) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      return;
    end
    // Envelope: a string here is the wrong kind
    if (bad_fld == FLD_ENVELOPE) begin
      push_string($urandom_range(0, 3));
    end else if ($urandom_range(0, 1)) begin
      frame_q.push_back(RLP_LIST_SHORT + 8'($urandom_range(0, 55)));
    end else begin
      n = $urandom_range(1, 4);
      frame_q.push_back(RLP_LIST_LONG + 8'(n - 1));
      repeat (n) frame_q.push_back(8'($urandom));
    end
    for (int f = FLD_TYPE; f <= FLD_S; f++) begin
      if (f == FLD_TYPE && !type_on) continue;
      if (f != bad_fld) begin
        push_string(pick_len(f));
      end else if (bad_kind == 2) begin
        // Header too long for the gather buffer
        frame_q.push_back(($urandom_range(0, 1) ? 8'hbc : 8'hfc) + 8'($urandom_range(0, 3)));
        repeat (5) frame_q.push_back(8'($urandom));
      end else if (bad_kind == 1 && f != FLD_DATA && f != FLD_R && f != FLD_S) begin
        push_string(((f == FLD_RECIPIENT) ? 20 : 32) + $urandom_range(1, 3));
      end else begin
        frame_q.push_back(RLP_LIST_SHORT + 8'($urandom_range(0, 55)));
      end
    end
    if (mode >= 70 && mode < 80) begin
      repeat ($urandom_range(1, 2)) frame_q.push_back(8'($urandom));
    end else if (mode >= 60 && mode < 70) begin
      n = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > n) void'(frame_q.pop_back());
    end
  endtask

  initial begin
    int seg_end;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 1'b0;
    in_valid      <= 1'b0;
    op            <= OP_BYTE;
    data_byte     <= 8'h00;
    items_sent     = 0;
    type_on        = 1'b0;
    send_idle_pct  = send_gap_pct[0];
    recv_idle_pct  = recv_gap_pct[0];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    settle_and_set_type(1'b0);

    // Directed: wrong kinds, sticky fault, oversize, header overflow, a minimal
    // complete transaction and a byte after the finish.
    frame_q = {8'h05, 8'hff};
    send_frame();
    frame_q = {8'hc0, 8'hc1};
    send_frame();
    frame_q = {8'hc0, 8'ha1};
    send_frame();
    frame_q = {8'hfc, 8'hff, 8'h00, 8'h00, 8'h00, 8'h80};
    send_frame();
    frame_q = {8'hc9, 8'h80, 8'h00, 8'h7f, 8'h80, 8'h80, 8'h80, 8'h1b, 8'h80, 8'h80,
               8'hff};
    send_frame();

    // Random transactions over three idle phases, flipping the type register
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_gap_pct[ph];
      recv_idle_pct = recv_gap_pct[ph];
      for (int h = 0; h < 2; h++) begin
        settle_and_set_type(1'((h + ph) % 2));
        seg_end = items_sent + 140;
        while (items_sent < seg_end) begin
          build_tx();
          // Trim the last transaction so the segment ends on its item budget
          while (frame_q.size() > 0 && items_sent + frame_q.size() + 1 > seg_end)
            void'(frame_q.pop_back());
          send_frame();
        end
      end
    end

    // Drain, let the pipe go quiet, then give the verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
